/* src/dafm_pkg.sv */
`timescale 1ns / 1ps

package dafm_pkg;

  // Port and parameter defaults
  localparam int unsigned ADDR_PORT_W = 64;
  localparam int unsigned ADDR_W_DEF  = 64;
  localparam int unsigned BURST_W     = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 8;

  // Output field widths
  localparam int unsigned CHAN_W = 4;
  localparam int unsigned RANK_W = 4;
  localparam int unsigned BANK_W = 5;
  localparam int unsigned ROW_W  = 20;
  localparam int unsigned COL_W  = 16;

  // Saturation limits of the configured field widths
  localparam logic [2:0] CHAN_MAX = 3'd4;
  localparam logic [2:0] RANK_MAX = 3'd4;
  localparam logic [2:0] BANK_MAX = 3'd5;
  localparam logic [4:0] ROW_MAX  = 5'd20;
  localparam logic [4:0] COL_MAX  = 5'd16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_BITS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANK_BITS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_BITS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BITS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_BITS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BUS_BYTES_LOG = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_BURST = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAPPING_MODE  = 3'd7;

  // Field codes
  localparam logic [2:0] FLD_CHAN = 3'd0;
  localparam logic [2:0] FLD_RANK = 3'd1;
  localparam logic [2:0] FLD_BANK = 3'd2;
  localparam logic [2:0] FLD_ROW  = 3'd3;
  localparam logic [2:0] FLD_COL  = 3'd4;

  // Mapping modes, named by field order from most to least significant
  localparam logic [2:0] MODE_CH_RK_RW_CL_BK = 3'd0;
  localparam logic [2:0] MODE_CH_RW_CL_BK_RK = 3'd1;
  localparam logic [2:0] MODE_CH_RK_BK_CL_RW = 3'd2;
  localparam logic [2:0] MODE_CH_RK_BK_RW_CL = 3'd3;
  localparam logic [2:0] MODE_CH_RW_CL_RK_BK = 3'd4;
  localparam logic [2:0] MODE_CH_RW_BK_RK_CL = 3'd5;
  localparam logic [2:0] MODE_RW_CL_RK_BK_CH = 3'd6;
  localparam logic [2:0] MODE_UNUSED         = 3'd7;

  localparam int unsigned NUM_FIELDS = 5;

  typedef struct packed {
    logic [2:0] channel_bits;
    logic [2:0] rank_bits;
    logic [2:0] bank_bits;
    logic [4:0] row_bits;
    logic [4:0] column_bits;
    logic [2:0] bus_bytes_log2;
    logic [7:0] default_burst_length;
    logic [2:0] mapping_mode;
  } cfg_t;

  // Effective field widths after saturation
  typedef struct packed {
    logic [2:0] chan;
    logic [2:0] rank;
    logic [2:0] bank;
    logic [4:0] row;
    logic [4:0] col;
  } fwidth_t;

  // Bit offsets of each field in the aligned address
  typedef struct packed {
    logic [5:0] chan;
    logic [5:0] rank;
    logic [5:0] bank;
    logic [5:0] row;
    logic [5:0] col;
  } foffs_t;

  typedef struct packed {
    fwidth_t    w;
    logic [3:0] shift;
    logic       err;
    logic [2:0] mode;
  } dec_t;

  typedef struct packed {
    fwidth_t w;
    foffs_t  off;
    logic    err;
    logic    zero;
  } aln_t;

  // Field peeled at position pos (0 is least significant) in a mode
  function automatic logic [2:0] field_at(input logic [2:0] mode, input int unsigned pos);
    logic [14:0] seq;
    seq = '0;
    unique case (mode)
      MODE_CH_RK_RW_CL_BK: seq = {FLD_CHAN, FLD_RANK, FLD_ROW, FLD_COL, FLD_BANK};
      MODE_CH_RW_CL_BK_RK: seq = {FLD_CHAN, FLD_ROW, FLD_COL, FLD_BANK, FLD_RANK};
      MODE_CH_RK_BK_CL_RW: seq = {FLD_CHAN, FLD_RANK, FLD_BANK, FLD_COL, FLD_ROW};
      MODE_CH_RK_BK_RW_CL: seq = {FLD_CHAN, FLD_RANK, FLD_BANK, FLD_ROW, FLD_COL};
      MODE_CH_RW_CL_RK_BK: seq = {FLD_CHAN, FLD_ROW, FLD_COL, FLD_RANK, FLD_BANK};
      MODE_CH_RW_BK_RK_CL: seq = {FLD_CHAN, FLD_ROW, FLD_BANK, FLD_RANK, FLD_COL};
      MODE_RW_CL_RK_BK_CH: seq = {FLD_ROW, FLD_COL, FLD_RANK, FLD_BANK, FLD_CHAN};
      default:             seq = '0;
    endcase
    return seq[3*pos +: 3];
  endfunction

endpackage

/* src/dafm_chan_if.sv */
`timescale 1ns / 1ps

interface dafm_in_if;
  logic                             valid;
  logic                             ready;
  logic [dafm_pkg::ADDR_PORT_W-1:0] physical_address;
  logic [dafm_pkg::BURST_W-1:0]     burst_length;

  modport source (output valid, physical_address, burst_length, input ready);
  modport sink   (input valid, physical_address, burst_length, output ready);
endinterface

interface dafm_out_if;
  logic                        valid;
  logic                        ready;
  logic [dafm_pkg::CHAN_W-1:0] channel;
  logic [dafm_pkg::RANK_W-1:0] rank;
  logic [dafm_pkg::BANK_W-1:0] bank;
  logic [dafm_pkg::ROW_W-1:0]  row;
  logic [dafm_pkg::COL_W-1:0]  column;
  logic                        width_error;

  modport source (output valid, channel, rank, bank, row, column, width_error, input ready);
  modport sink   (input valid, channel, rank, bank, row, column, width_error, output ready);
endinterface

/* src/dafm_cfg_regs.sv */
`timescale 1ns / 1ps

module dafm_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dafm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dafm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output dafm_pkg::cfg_t                    cfg
);
  import dafm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_CHANNEL_BITS:  cfg_nxt.channel_bits         = cfg_data[2:0];
        REG_RANK_BITS:     cfg_nxt.rank_bits            = cfg_data[2:0];
        REG_BANK_BITS:     cfg_nxt.bank_bits            = cfg_data[2:0];
        REG_ROW_BITS:      cfg_nxt.row_bits             = cfg_data[4:0];
        REG_COLUMN_BITS:   cfg_nxt.column_bits          = cfg_data[4:0];
        REG_BUS_BYTES_LOG: cfg_nxt.bus_bytes_log2       = cfg_data[2:0];
        REG_DEFAULT_BURST: cfg_nxt.default_burst_length = cfg_data[7:0];
        REG_MAPPING_MODE:  cfg_nxt.mapping_mode         = cfg_data[2:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_bits         <= 3'd0;
      cfg_r.rank_bits            <= 3'd1;
      cfg_r.bank_bits            <= 3'd3;
      cfg_r.row_bits             <= 5'd14;
      cfg_r.column_bits          <= 5'd10;
      cfg_r.bus_bytes_log2       <= 3'd3;
      cfg_r.default_burst_length <= 8'd8;
      cfg_r.mapping_mode         <= MODE_CH_RK_RW_CL_BK;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* src/dafm_decode.sv */
`timescale 1ns / 1ps

module dafm_decode #(
  parameter int unsigned ADDRESS_WIDTH = dafm_pkg::ADDR_W_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dafm_pkg::cfg_t           cfg,
  dafm_in_if.sink                  in_chan,
  output logic                     dec_valid,
  input  logic                     dec_ready,
  output logic [ADDRESS_WIDTH-1:0] dec_addr,
  output dafm_pkg::dec_t           dec
);
  import dafm_pkg::*;

  logic                     valid_r;
  logic [ADDRESS_WIDTH-1:0] addr_r;
  dec_t                     dec_r;
  dec_t                     dec_nxt;
  logic [7:0]               burst_sel;
  logic [2:0]               col_low;
  logic [4:0]               col_full;
  logic                     load;

  assign in_chan.ready = !valid_r || dec_ready;
  assign load          = in_chan.valid && in_chan.ready;

  // Pick the burst length and find its floor log2
  always_comb begin
    burst_sel = (in_chan.burst_length == '0) ? cfg.default_burst_length
                                             : in_chan.burst_length;
    col_low = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (burst_sel[i]) col_low = 3'(i);
    end
  end

  // Saturate widths and size the column field
  always_comb begin
    dec_nxt.w.chan = (cfg.channel_bits > CHAN_MAX) ? CHAN_MAX : cfg.channel_bits;
    dec_nxt.w.rank = (cfg.rank_bits > RANK_MAX) ? RANK_MAX : cfg.rank_bits;
    dec_nxt.w.bank = (cfg.bank_bits > BANK_MAX) ? BANK_MAX : cfg.bank_bits;
    dec_nxt.w.row  = (cfg.row_bits > ROW_MAX) ? ROW_MAX : cfg.row_bits;
    col_full       = (cfg.column_bits > COL_MAX) ? COL_MAX : cfg.column_bits;
    dec_nxt.err    = {2'b00, col_low} > col_full;
    dec_nxt.w.col  = dec_nxt.err ? 5'd0 : col_full - {2'b00, col_low};
    dec_nxt.shift  = {1'b0, cfg.bus_bytes_log2} + {1'b0, col_low};
    dec_nxt.mode   = cfg.mapping_mode;
  end

  // Hold valid; advance payload on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr_r <= in_chan.physical_address[ADDRESS_WIDTH-1:0];
      dec_r  <= dec_nxt;
    end
  end

  assign dec_valid = valid_r;
  assign dec_addr  = addr_r;
  assign dec       = dec_r;

endmodule

/* src/dafm_align.sv */
`timescale 1ns / 1ps

module dafm_align #(
  parameter int unsigned ADDRESS_WIDTH = dafm_pkg::ADDR_W_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     dec_valid,
  output logic                     dec_ready,
  input  logic [ADDRESS_WIDTH-1:0] dec_addr,
  input  dafm_pkg::dec_t           dec,
  output logic                     aln_valid,
  input  logic                     aln_ready,
  output logic [ADDRESS_WIDTH-1:0] aln_addr,
  output dafm_pkg::aln_t           aln
);
  import dafm_pkg::*;

  logic                     valid_r;
  logic [ADDRESS_WIDTH-1:0] addr_r;
  logic [ADDRESS_WIDTH-1:0] addr_nxt;
  aln_t                     aln_r;
  aln_t                     aln_nxt;
  logic [5:0]               run;
  logic [2:0]               fld;
  logic                     load;

  assign dec_ready = !valid_r || aln_ready;
  assign load      = dec_valid && dec_ready;

  // Drop byte offset and burst-covered column bits
  assign addr_nxt = dec_addr >> dec.shift;

  // Accumulate field offsets in peel order
  always_comb begin
    run          = 6'd0;
    fld          = FLD_CHAN;
    aln_nxt.off  = '0;
    for (int p = 0; p < NUM_FIELDS; p++) begin
      fld = field_at(dec.mode, p);
      case (fld)
        FLD_CHAN: begin
          aln_nxt.off.chan = run;
          run = run + 6'(dec.w.chan);
        end
        FLD_RANK: begin
          aln_nxt.off.rank = run;
          run = run + 6'(dec.w.rank);
        end
        FLD_BANK: begin
          aln_nxt.off.bank = run;
          run = run + 6'(dec.w.bank);
        end
        FLD_ROW: begin
          aln_nxt.off.row = run;
          run = run + 6'(dec.w.row);
        end
        FLD_COL: begin
          aln_nxt.off.col = run;
          run = run + 6'(dec.w.col);
        end
        default: begin
          run = run;
        end
      endcase
    end
    aln_nxt.w    = dec.w;
    aln_nxt.err  = dec.err;
    aln_nxt.zero = (dec.mode == MODE_UNUSED);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (dec_ready) begin
      valid_r <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr_r <= addr_nxt;
      aln_r  <= aln_nxt;
    end
  end

  assign aln_valid = valid_r;
  assign aln_addr  = addr_r;
  assign aln       = aln_r;

endmodule

/* src/dafm_extract.sv */
`timescale 1ns / 1ps

module dafm_extract #(
  parameter int unsigned ADDRESS_WIDTH = dafm_pkg::ADDR_W_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     aln_valid,
  output logic                     aln_ready,
  input  logic [ADDRESS_WIDTH-1:0] aln_addr,
  input  dafm_pkg::aln_t           aln,
  dafm_out_if.source               out_chan
);
  import dafm_pkg::*;

  logic              valid_r;
  logic [CHAN_W-1:0] chan_r, chan_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [BANK_W-1:0] bank_r, bank_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              err_r;
  logic [63:0]       addr_ext;
  logic [63:0]       e_chan, e_rank, e_bank, e_row, e_col;
  logic [CHAN_W:0]   m_chan;
  logic [RANK_W:0]   m_rank;
  logic [BANK_W:0]   m_bank;
  logic [ROW_W:0]    m_row;
  logic [COL_W:0]    m_col;
  logic              load;

  assign aln_ready = !valid_r || out_chan.ready;
  assign load      = aln_valid && aln_ready;

  // Shift each field down to bit zero and mask to its width; the unused mapping mode gives all zeros
  always_comb begin
    addr_ext = 64'(aln_addr);
    e_chan   = addr_ext >> aln.off.chan;
    e_rank   = addr_ext >> aln.off.rank;
    e_bank   = addr_ext >> aln.off.bank;
    e_row    = addr_ext >> aln.off.row;
    e_col    = addr_ext >> aln.off.col;
    m_chan   = ((CHAN_W+1)'(1) << aln.w.chan) - (CHAN_W+1)'(1);
    m_rank   = ((RANK_W+1)'(1) << aln.w.rank) - (RANK_W+1)'(1);
    m_bank   = ((BANK_W+1)'(1) << aln.w.bank) - (BANK_W+1)'(1);
    m_row    = ((ROW_W+1)'(1) << aln.w.row) - (ROW_W+1)'(1);
    m_col    = ((COL_W+1)'(1) << aln.w.col) - (COL_W+1)'(1);
    if (aln.zero) begin
      chan_nxt = '0;
      rank_nxt = '0;
      bank_nxt = '0;
      row_nxt  = '0;
      col_nxt  = '0;
    end else begin
      chan_nxt = e_chan[CHAN_W-1:0] & m_chan[CHAN_W-1:0];
      rank_nxt = e_rank[RANK_W-1:0] & m_rank[RANK_W-1:0];
      bank_nxt = e_bank[BANK_W-1:0] & m_bank[BANK_W-1:0];
      row_nxt  = e_row[ROW_W-1:0] & m_row[ROW_W-1:0];
      col_nxt  = e_col[COL_W-1:0] & m_col[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (aln_ready) begin
      valid_r <= aln_valid;
    end
  end

  // Output register; hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (load) begin
      chan_r <= chan_nxt;
      rank_r <= rank_nxt;
      bank_r <= bank_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      err_r  <= aln.err;
    end
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.channel     = chan_r;
  assign out_chan.rank        = rank_r;
  assign out_chan.bank        = bank_r;
  assign out_chan.row         = row_r;
  assign out_chan.column      = col_r;
  assign out_chan.width_error = err_r;

endmodule

/* src/dram_address_field_mapper_unit.sv */
`timescale 1ns / 1ps

// DRAM address field mapper.
// in_chan carries a byte address and a burst length (zero picks the default
// burst register); out_chan returns channel, rank, bank, row, high column
// bits and a width error flag. Both are valid/ready; a transfer happens on a
// clock edge with valid and ready high. Only the low ADDRESS_WIDTH address
// bits are used.
// The cfg_ port writes one register per edge with cfg_we high; write it only
// while no request is in flight.
// Output valid rises once the request has been registered in turn in the
// three stages: decode and width saturation, offset alignment, field
// extraction into the output register.
// Throughput is one request per cycle while the receiver is ready.
// Each stage takes a new request when empty or when the stage after it moves,
// so requests keep entering while a result waits, up to three in flight.
// A stalled receiver holds the output register; backpressure then ripples up
// stage by stage with nothing dropped or repeated.
// Synchronous reset empties the pipeline and loads the default register set.

module dram_address_field_mapper_unit #(
  parameter int unsigned ADDRESS_WIDTH = dafm_pkg::ADDR_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dafm_in_if.sink                         in_chan,
  dafm_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [dafm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dafm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dafm_pkg::*;

  cfg_t                     cfg;
  logic                     dec_valid, dec_ready;
  logic [ADDRESS_WIDTH-1:0] dec_addr;
  dec_t                     dec;
  logic                     aln_valid, aln_ready;
  logic [ADDRESS_WIDTH-1:0] aln_addr;
  aln_t                     aln;

  dafm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dafm_decode #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_chan   (in_chan),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_addr  (dec_addr),
    .dec       (dec)
  );

  dafm_align #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_align (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_addr  (dec_addr),
    .dec       (dec),
    .aln_valid (aln_valid),
    .aln_ready (aln_ready),
    .aln_addr  (aln_addr),
    .aln       (aln)
  );

  dafm_extract #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_extract (
    .clk       (clk),
    .rst_n     (rst_n),
    .aln_valid (aln_valid),
    .aln_ready (aln_ready),
    .aln_addr  (aln_addr),
    .aln       (aln),
    .out_chan  (out_chan)
  );

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("output valid after reset");

  // A ready receiver lets the whole pipeline take input
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.ready |-> in_chan.ready)
    else $error("input stalled while receiver ready");

  // A decoded request moves into the align stage when it has room
  a_dec_advance: assert property (@(posedge clk) disable iff (!rst_n)
    dec_valid && dec_ready |=> aln_valid)
    else $error("request lost between decode and align");

  // A width error always yields an empty column field
  a_err_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.width_error |-> out_chan.column == '0)
    else $error("column nonzero with width error");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import dafm_pkg::*;

  localparam int unsigned ADDR_BITS   = ADDR_W_DEF;
  localparam int unsigned PIPE_DEPTH  = 3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_PHASES = 20;
  localparam int unsigned PHASE_ITEMS = 40;

  typedef struct packed {
    logic [ADDR_PORT_W-1:0] addr;
    logic [BURST_W-1:0]     burst;
  } map_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [RANK_W-1:0] rank;
    logic [BANK_W-1:0] bank;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic              width_error;
  } dram_coord_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dafm_in_if  in_if ();
  dafm_out_if out_if ();

  dram_address_field_mapper_unit #(
    .ADDRESS_WIDTH (ADDR_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the register file, indexed by register index
  logic [CFG_DATA_W-1:0] map_regs [8];

  map_req_t    addr_queue [$];
  dram_coord_t coord_queue [$];

  logic        in_taken  = 1'b0;
  logic        out_taken = 1'b0;
  int unsigned in_gap    = 0;
  int unsigned out_stall = 0;
  logic        in_idle   = 1'b0;
  logic        out_idle  = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;

  always #10 clk = ~clk;

  function automatic int unsigned clamp(input int unsigned v, input int unsigned m);
    return (v > m) ? m : v;
  endfunction

  // Split one address into DRAM coordinates under the current register set
  function automatic dram_coord_t map_address(input logic [63:0] addr,
                                              input logic [7:0] burst);
    logic [7:0]  blen;
    int unsigned col_low;
    int unsigned col_full;
    int unsigned w [NUM_FIELDS];
    logic [63:0] a;
    logic [19:0] val [NUM_FIELDS];
    logic [14:0] order;
    logic [2:0]  f;
    logic [2:0]  mode;
    dram_coord_t r;
    a = addr;
    if (ADDR_BITS < 64) a = a & ((64'd1 << ADDR_BITS) - 64'd1);
    blen = (burst == 8'd0) ? map_regs[REG_DEFAULT_BURST] : burst;
    col_low = 0;
    for (int i = 0; i < 8; i++) begin
      if (blen[i]) col_low = i;
    end
    w[FLD_CHAN] = clamp(map_regs[REG_CHANNEL_BITS][2:0], CHAN_MAX);
    w[FLD_RANK] = clamp(map_regs[REG_RANK_BITS][2:0], RANK_MAX);
    w[FLD_BANK] = clamp(map_regs[REG_BANK_BITS][2:0], BANK_MAX);
    w[FLD_ROW]  = clamp(map_regs[REG_ROW_BITS][4:0], ROW_MAX);
    col_full    = clamp(map_regs[REG_COLUMN_BITS][4:0], COL_MAX);
    r = '0;
    r.width_error = (col_low > col_full);
    w[FLD_COL] = r.width_error ? 0 : col_full - col_low;
    a = a >> map_regs[REG_BUS_BYTES_LOG][2:0];
    a = a >> col_low;
    for (int i = 0; i < NUM_FIELDS; i++) val[i] = '0;
    // Field list, most significant first; peeling starts at the low end
    mode = map_regs[REG_MAPPING_MODE][2:0];
    case (mode)
      MODE_CH_RK_RW_CL_BK: order = {FLD_CHAN, FLD_RANK, FLD_ROW, FLD_COL, FLD_BANK};
      MODE_CH_RW_CL_BK_RK: order = {FLD_CHAN, FLD_ROW, FLD_COL, FLD_BANK, FLD_RANK};
      MODE_CH_RK_BK_CL_RW: order = {FLD_CHAN, FLD_RANK, FLD_BANK, FLD_COL, FLD_ROW};
      MODE_CH_RK_BK_RW_CL: order = {FLD_CHAN, FLD_RANK, FLD_BANK, FLD_ROW, FLD_COL};
      MODE_CH_RW_CL_RK_BK: order = {FLD_CHAN, FLD_ROW, FLD_COL, FLD_RANK, FLD_BANK};
      MODE_CH_RW_BK_RK_CL: order = {FLD_CHAN, FLD_ROW, FLD_BANK, FLD_RANK, FLD_COL};
      MODE_RW_CL_RK_BK_CH: order = {FLD_ROW, FLD_COL, FLD_RANK, FLD_BANK, FLD_CHAN};
      default:             order = '0;
    endcase
    if (mode != MODE_UNUSED) begin
      for (int p = 0; p < NUM_FIELDS; p++) begin
        f = order[3*p +: 3];
        val[f] = 20'(a & ((64'd1 << w[f]) - 64'd1));
        a = a >> w[f];
      end
    end
    r.channel = val[FLD_CHAN][CHAN_W-1:0];
    r.rank    = val[FLD_RANK][RANK_W-1:0];
    r.bank    = val[FLD_BANK][BANK_W-1:0];
    r.row     = val[FLD_ROW][ROW_W-1:0];
    r.column  = val[FLD_COL][COL_W-1:0];
    return r;
  endfunction

  // Record transfers, predict on input, check on output
  always @(posedge clk) begin : monitor
    dram_coord_t got;
    dram_coord_t want;
    in_taken  <= rst_n && in_if.valid && in_if.ready;
    out_taken <= rst_n && out_if.valid && out_if.ready;
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        coord_queue.push_back(map_address(in_if.physical_address, in_if.burst_length));
      if (out_if.valid && out_if.ready) begin
        got = {out_if.channel, out_if.rank, out_if.bank, out_if.row, out_if.column,
               out_if.width_error};
        if (coord_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: ch=%0d rk=%0d bk=%0d row=%0h col=%0h err=%0d",
                     got.channel, got.rank, got.bank, got.row, got.column,
                     got.width_error);
        end else begin
          want = coord_queue.pop_front();
          if (got.channel !== want.channel || got.rank !== want.rank ||
              got.bank !== want.bank || got.row !== want.row ||
              got.column !== want.column || got.width_error !== want.width_error) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp ch=%0d rk=%0d bk=%0d row=%0h col=%0h err=%0d",
                       want.channel, want.rank, want.bank, want.row, want.column,
                       want.width_error, "  got ch=%0d rk=%0d bk=%0d row=%0h col=%0h err=%0d",
                       got.channel, got.rank, got.bank, got.row, got.column,
                       got.width_error);
          end
        end
      end
    end
  end

  // Present requests; hold until transfer, then wait the drawn gap
  always @(negedge clk) begin : request_drive
    map_req_t item;
    if (rst_n && (!in_if.valid || in_taken)) begin
      if (in_gap > 0) begin
        in_if.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (addr_queue.size() > 0) begin
        item = addr_queue.pop_front();
        in_if.valid            <= 1'b1;
        in_if.physical_address <= item.addr;
        in_if.burst_length     <= item.burst;
        in_gap <= in_idle ? $urandom_range(0, 6) : 0;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Stall the result side for a drawn number of cycles after each transfer
  always @(negedge clk) begin : ready_drive
    int unsigned n;
    if (rst_n) begin
      n = out_stall;
      if (out_taken) n = out_idle ? $urandom_range(0, 6) : 0;
      if (n == 0) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        n = n - 1;
      end
      out_stall <= n;
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    map_regs[idx] = data;
  endtask

  task automatic cfg_done;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Write every register; widths saturate, so push them past the field limits
  task automatic cfg_set(input logic [7:0] chan, input logic [7:0] rank,
                         input logic [7:0] bank, input logic [7:0] row,
                         input logic [7:0] col, input logic [7:0] bus,
                         input logic [7:0] dflt, input logic [7:0] mode);
    cfg_write(REG_CHANNEL_BITS, chan);
    cfg_write(REG_RANK_BITS, rank);
    cfg_write(REG_BANK_BITS, bank);
    cfg_write(REG_ROW_BITS, row);
    cfg_write(REG_COLUMN_BITS, col);
    cfg_write(REG_BUS_BYTES_LOG, bus);
    cfg_write(REG_DEFAULT_BURST, dflt);
    cfg_write(REG_MAPPING_MODE, mode);
    cfg_done();
  endtask

  task automatic cfg_random;
    logic [7:0] top;
    logic [7:0] v;
    for (int i = 0; i < 8; i++) begin
      case (i[CFG_IDX_W-1:0])
        REG_ROW_BITS, REG_COLUMN_BITS: top = 8'd31;
        REG_DEFAULT_BURST:             top = 8'd255;
        default:                       top = 8'd7;
      endcase
      case ($urandom_range(0, 7))
        0:       v = 8'd0;
        1:       v = top;
        2:       v = 8'($urandom_range(0, 255));
        default: v = 8'($urandom_range(0, top));
      endcase
      cfg_write(i[CFG_IDX_W-1:0], v);
    end
    cfg_done();
  endtask

  task automatic queue_item(input logic [63:0] addr, input logic [7:0] burst);
    addr_queue.push_back('{addr: addr, burst: burst});
  endtask

  // Wait until every request has gone through, then let the pipe settle
  task automatic wait_drained;
    while (addr_queue.size() != 0 || coord_queue.size() != 0 || in_if.valid)
      @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_address;
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      2:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] rand_burst;
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd1 << $urandom_range(0, 7);
      2:       return 8'd255;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.physical_address = '0;
    in_if.burst_length     = '0;
    out_if.ready = 1'b0;
    map_regs[REG_CHANNEL_BITS]  = 8'd0;
    map_regs[REG_RANK_BITS]     = 8'd1;
    map_regs[REG_BANK_BITS]     = 8'd3;
    map_regs[REG_ROW_BITS]      = 8'd14;
    map_regs[REG_COLUMN_BITS]   = 8'd10;
    map_regs[REG_BUS_BYTES_LOG] = 8'd3;
    map_regs[REG_DEFAULT_BURST] = 8'd8;
    map_regs[REG_MAPPING_MODE]  = 8'(MODE_CH_RK_RW_CL_BK);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset register set: address extremes, default burst and burst extremes
    queue_item(64'd0, 8'd0);
    queue_item('1, 8'd0);
    queue_item('1, 8'd1);
    queue_item('1, 8'd255);
    queue_item(64'h0123_4567_89AB_CDEF, 8'd128);
    queue_item(64'hAAAA_AAAA_AAAA_AAAA, 8'd2);
    wait_drained();

    // Oversized widths and a zero default burst, through every mapping mode code
    for (int m = 0; m < 8; m++) begin
      cfg_set(8'd7, 8'd7, 8'd7, 8'd31, 8'd31, 8'd7, 8'd0, m[7:0]);
      queue_item(64'h0123_4567_89AB_CDEF, 8'd0);
      queue_item(64'hFEDC_BA98_7654_3210, 8'd0);
      wait_drained();
    end

    // Burst wider than the column field, and one exactly as wide
    cfg_set(8'd2, 8'd1, 8'd3, 8'd14, 8'd2, 8'd0, 8'd8, 8'(MODE_CH_RK_BK_RW_CL));
    queue_item(64'h0123_4567_89AB_CDEF, 8'd8);
    queue_item(64'h0123_4567_89AB_CDEF, 8'd4);
    wait_drained();

    // Random register sets with random traffic and backpressure
    for (int p = 0; p < RAND_PHASES; p++) begin
      cfg_random();
      in_idle  = ($urandom_range(0, 3) != 0);
      out_idle = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++)
        queue_item(rand_address(), rand_burst());
      wait_drained();
    end

    repeat (10) @(posedge clk);
    mismatches += coord_queue.size();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
